// ===== hdl/grvd_pkg.sv =====
// Shared types and constants for the gain / RMS voice detector.
package grvd_pkg;

    // Register map indexes (byte address = 4 * index)
    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_VAD_EN    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [6:0]  GAIN_RESET = 7'd64;
    localparam logic [6:0]  GAIN_MAX   = 7'd100;
    localparam logic [14:0] LEVEL_MAX  = 15'd32767;

    // Main sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CLIP,
        ST_SQUARE,
        ST_ACC,
        ST_START,
        ST_WAIT,
        ST_DONE
    } grvd_state_t;

    // Divide / root unit states
    typedef enum logic [1:0] {
        DR_IDLE,
        DR_DIV,
        DR_ROOT,
        DR_DONE
    } grvd_dr_state_t;

endpackage

// ===== hdl/grvd_divroot.sv =====
// Serial divide of the frame square sum by the sample count, then serial integer root.
module grvd_divroot #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [SUM_W-1:0]            sum,
    input  logic [CNT_W-1:0]            count,
    output logic                        done,
    output logic [(SUM_W+1)/2-1:0]      root
);
    import grvd_pkg::*;

    localparam int R_W   = (SUM_W + 1) / 2;
    localparam int Q_W   = 2 * R_W;
    localparam int SUB_W = (CNT_W + 1 > R_W + 3) ? CNT_W + 1 : R_W + 3;
    localparam int IT_W  = $clog2(SUM_W + 1);

    grvd_dr_state_t     state_reg, state_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [SUB_W-1:0]   rem_reg, rem_next;
    logic [R_W-1:0]     res_reg, res_next;
    logic [CNT_W-1:0]   div_reg;
    logic [IT_W-1:0]    iter_reg, iter_next;

    // Shared compare / subtract unit
    logic [SUB_W-1:0]   sub_a, sub_b;
    logic [SUB_W:0]     diff;
    logic               ge;

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            DR_DIV:
            begin
                sub_a = SUB_W'({rem_reg[CNT_W-1:0], q_reg[SUM_W-1]});
                sub_b = SUB_W'(div_reg);
            end
            DR_ROOT:
            begin
                sub_a = {rem_reg[SUB_W-3:0], q_reg[Q_W-1:Q_W-2]};
                sub_b = SUB_W'({res_reg, 2'b01});
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[SUB_W];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DR_IDLE: if (start) state_next = DR_DIV;
            DR_DIV:  if (iter_reg == '0) state_next = DR_ROOT;
            DR_ROOT: if (iter_reg == '0) state_next = DR_DONE;
            DR_DONE: state_next = DR_IDLE;
            default: state_next = DR_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        iter_next = iter_reg;
        case (state_reg)
            DR_IDLE:
            begin
                q_next    = Q_W'(sum);
                rem_next  = '0;
                res_next  = '0;
                iter_next = IT_W'(SUM_W - 1);
            end
            DR_DIV:
            begin
                q_next[SUM_W-1:0] = {q_reg[SUM_W-2:0], ge};
                rem_next          = ge ? diff[SUB_W-1:0] : sub_a;
                if (iter_reg == '0)
                begin
                    rem_next  = '0;
                    iter_next = IT_W'(R_W - 1);
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            DR_ROOT:
            begin
                q_next    = {q_reg[Q_W-3:0], 2'b00};
                rem_next  = ge ? diff[SUB_W-1:0] : sub_a;
                res_next  = {res_reg[R_W-2:0], ge};
                iter_next = iter_reg - 1'b1;
            end
            default:
            begin
                iter_next = iter_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        done = (state_reg == DR_DONE);
        root = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DR_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (state_reg == DR_IDLE)
        begin
            div_reg <= count;
        end
    end

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == DR_IDLE)
        else $error("divroot started while busy");

    a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DR_DIV && iter_reg == '0) |=> state_reg == DR_ROOT)
        else $error("divide did not hand over to root");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == DR_IDLE)
        else $error("done longer than one cycle");

endmodule

// ===== hdl/gain_rms_voice_detector.sv =====
// Top level: gain scaling, frame RMS level and voice activity detection.
//
// Input channel (in_valid/in_ready) carries one audio sample per transfer with
// frame_last and now_ms. Output channel (out_valid/out_ready) returns exactly one
// result per input: the gain-scaled, clipped sample, plus level and voice flags
// on the last sample of a frame (zero otherwise).
// Registers are written over the APB port: gain (0x0), vad_enable (0x4),
// vad_threshold (0x8), silence_timeout (0xC); pready is tied high.
// Sequencing: one 17x17 multiplier is reused for gain and square. An ordinary
// sample passes the scale, clip, square and accumulate steps before its result
// is loaded into the output register, and the next input is taken only once
// the sequencer is back in idle. A frame-end sample adds a start step, the
// serial divide (SUM_W quotient bits, 41 at the default frame size), the root
// ((SUM_W+1)/2 = 21 bits) and a hand-back step, all in one shared subtractor.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register so the next input can be taken while it waits. If the
// receiver stalls, the following result waits in the last sequencer step.
// Reset clears the sequencer, the frame sum and count, voice state and sets
// the registers to gain 64, detection off, threshold 0, timeout 0.
module gain_rms_voice_detector #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample_in,
    input  logic               frame_last,
    input  logic [31:0]        now_ms,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic               frame_end,
    output logic [14:0]        rms_level,
    output logic               voice_flag,
    output logic               voice_changed,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import grvd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W = 30 + CNT_W;
    localparam int R_W   = (SUM_W + 1) / 2;

    grvd_state_t         state_reg, state_next;

    // configuration
    logic [6:0]          gain_reg;
    logic                vad_enable_reg;
    logic [14:0]         vad_threshold_reg;
    logic [31:0]         silence_timeout_reg;

    // item and arithmetic
    logic signed [15:0]  sample_reg;
    logic                last_reg;
    logic [31:0]         now_reg;
    logic signed [33:0]  prod_reg;
    logic signed [15:0]  scaled_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;

    // frame state
    logic [14:0]         level_reg;
    logic                voice_active_reg;
    logic [31:0]         silence_start_reg;
    logic                reported_voice_reg;
    logic                frame_voice;
    logic                frame_changed;

    // output register
    logic                out_valid_reg;
    logic signed [15:0]  sample_out_reg;
    logic                frame_end_reg;
    logic [14:0]         rms_level_reg;
    logic                voice_flag_reg;
    logic                voice_changed_reg;

    // control
    logic                in_xfer;
    logic                out_load;
    logic                dr_start;
    logic                dr_done;
    logic [R_W-1:0]      dr_root;
    logic                cfg_wr;

    // shared multiplier
    logic signed [16:0]  mul_a, mul_b;
    logic signed [33:0]  mul_p;

    // clip path
    logic signed [33:0]  adj;
    logic signed [33:0]  shq;
    logic signed [15:0]  clip_val;

    // frame-end voice logic
    logic                loud;
    logic                timed_out;
    logic                va_new;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign in_xfer = in_valid & in_ready;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg            <= GAIN_RESET;
            vad_enable_reg      <= 1'b0;
            vad_threshold_reg   <= '0;
            silence_timeout_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GAIN:      gain_reg <= (pwdata[6:0] > GAIN_MAX) ? GAIN_MAX : pwdata[6:0];
                REG_VAD_EN:    vad_enable_reg <= pwdata[0];
                REG_THRESHOLD: vad_threshold_reg <= pwdata[14:0];
                REG_TIMEOUT:   silence_timeout_reg <= pwdata;
                default:       gain_reg <= gain_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_GAIN:      prdata = 32'(gain_reg);
            REG_VAD_EN:    prdata = 32'(vad_enable_reg);
            REG_THRESHOLD: prdata = 32'(vad_threshold_reg);
            REG_TIMEOUT:   prdata = silence_timeout_reg;
            default:       prdata = '0;
        endcase
    end

    // Multiplier operand select: gain in SCALE, square in SQUARE
    always_comb
    begin
        if (state_reg == ST_SQUARE)
        begin
            mul_a = {scaled_reg[15], scaled_reg};
            mul_b = {scaled_reg[15], scaled_reg};
        end
        else
        begin
            mul_a = {sample_reg[15], sample_reg};
            mul_b = $signed({10'b0, gain_reg});
        end
    end

    assign mul_p = mul_a * mul_b;

    // Divide by 64 toward zero, then clip to 16 bits
    always_comb
    begin
        adj = prod_reg + (prod_reg[33] ? 34'sd63 : 34'sd0);
        shq = adj >>> 6;
        if (shq > 34'sd32767)
            clip_val = 16'sh7FFF;
        else if (shq < -34'sd32768)
            clip_val = -16'sh8000;
        else
            clip_val = shq[15:0];
    end

    // Voice decision at frame end
    always_comb
    begin
        loud      = level_reg > vad_threshold_reg;
        timed_out = (now_reg - silence_start_reg) > silence_timeout_reg;
        if (loud)
            va_new = 1'b1;
        else if (voice_active_reg && timed_out)
            va_new = 1'b0;
        else
            va_new = voice_active_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_CLIP;
            ST_CLIP:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ACC;
            ST_ACC:    state_next = last_reg ? ST_START : ST_DONE;
            ST_START:  state_next = ST_WAIT;
            ST_WAIT:   if (dr_done) state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        dr_start = (state_reg == ST_START);
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    grvd_divroot #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divroot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dr_start),
        .sum   (sum_reg),
        .count (count_reg),
        .done  (dr_done),
        .root  (dr_root)
    );

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            sum_reg            <= '0;
            count_reg          <= '0;
            level_reg          <= '0;
            voice_active_reg   <= 1'b0;
            silence_start_reg  <= '0;
            reported_voice_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // accumulate while the frame has room
            if (state_reg == ST_ACC && count_reg < CNT_W'(MAX_FRAME_SAMPLES))
            begin
                sum_reg   <= sum_reg + SUM_W'(prod_reg[30:0]);
                count_reg <= count_reg + 1'b1;
            end

            // frame end: level, clear frame, voice update
            if (state_reg == ST_WAIT && dr_done)
            begin
                level_reg <= (dr_root > R_W'(LEVEL_MAX)) ? LEVEL_MAX : dr_root[14:0];
                sum_reg   <= '0;
                count_reg <= '0;
            end

            if (state_reg == ST_DONE && last_reg && vad_enable_reg && out_load)
            begin
                voice_active_reg   <= va_new;
                reported_voice_reg <= va_new;
                if (loud)
                    silence_start_reg <= now_reg;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= sample_in;
            last_reg   <= frame_last;
            now_reg    <= now_ms;
        end
        if (state_reg == ST_SCALE || state_reg == ST_SQUARE)
            prod_reg <= mul_p;
        if (state_reg == ST_CLIP)
            scaled_reg <= clip_val;
        if (out_load)
        begin
            sample_out_reg    <= scaled_reg;
            frame_end_reg     <= last_reg;
            rms_level_reg     <= last_reg ? level_reg : '0;
            voice_flag_reg    <= last_reg ? frame_voice : 1'b0;
            voice_changed_reg <= last_reg ? frame_changed : 1'b0;
        end
    end

    // Voice flags for the result, shown with the level
    always_comb
    begin
        if (vad_enable_reg)
        begin
            frame_voice   = va_new;
            frame_changed = va_new != reported_voice_reg;
        end
        else
        begin
            frame_voice   = 1'b1;
            frame_changed = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign frame_end     = frame_end_reg;
    assign rms_level     = rms_level_reg;
    assign voice_flag    = voice_flag_reg;
    assign voice_changed = voice_changed_reg;

    // Checks
    a_in_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_SCALE)
        else $error("input transfer did not start the sequencer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME_SAMPLES))
        else $error("sample count past frame limit");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dr_done |-> state_reg == ST_WAIT)
        else $error("divroot finished outside wait state");

endmodule

// ===== dv/tb_gain_rms_voice_detector.sv =====
// Self-checking testbench for gain_rms_voice_detector: scoreboard predicts every output transfer.
module tb_gain_rms_voice_detector;
    import grvd_pkg::*;

    localparam int FRAME_CAP   = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 100;

    // One output transfer as the block should present it
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic [14:0]        level;
        logic               voice;
        logic               changed;
    } voice_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] sample_in;
    logic               frame_last;
    logic [31:0]        now_ms;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample_out;
    logic               frame_end;
    logic [14:0]        rms_level;
    logic               voice_flag;
    logic               voice_changed;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int          send_gap_pct;
    int          recv_gap_pct;
    bit          hold_req;
    logic [31:0] clock_ms;

    gain_rms_voice_detector DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .frame_last     (frame_last),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .frame_end      (frame_end),
        .rms_level      (rms_level),
        .voice_flag     (voice_flag),
        .voice_changed  (voice_changed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Scoreboard: register copy, frame energy / voice state, queue of pending results
    class voice_scoreboard;
        logic [6:0]      gain_q;
        logic            vad_en_q;
        logic [14:0]     thr_q;
        logic [31:0]     timeout_q;
        longint unsigned energy;
        int unsigned     n_samples;
        logic            active;
        logic [31:0]     quiet_since;
        logic            shown_voice;
        voice_result_t   pending_q[$];
        int              errors;

        function new();
            gain_q      = GAIN_RESET;
            vad_en_q    = 1'b0;
            thr_q       = '0;
            timeout_q   = '0;
            energy      = 0;
            n_samples   = 0;
            active      = 1'b0;
            quiet_since = '0;
            shown_voice = 1'b0;
            errors      = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_GAIN:      gain_q = (val[6:0] > GAIN_MAX) ? GAIN_MAX : val[6:0];
                REG_VAD_EN:    vad_en_q = val[0];
                REG_THRESHOLD: thr_q = val[14:0];
                REG_TIMEOUT:   timeout_q = val;
                default:       ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_GAIN:      return {25'd0, gain_q};
                REG_VAD_EN:    return {31'd0, vad_en_q};
                REG_THRESHOLD: return {17'd0, thr_q};
                default:       return timeout_q;
            endcase
        endfunction

        // Largest r with r*r <= v, by bisection
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            lo = 0;
            hi = 64'd1 << 21;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid <= v)
                    lo = mid;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        // Predict the result of one accepted input transfer
        function void note_input(logic signed [15:0] s, logic last, logic [31:0] now);
            int              prod;
            longint unsigned mean;
            longint unsigned root;
            logic [31:0]     elapsed;
            voice_result_t   r;
            prod = (int'(s) * int'(gain_q)) / 64;
            if (prod > 32767)
                prod = 32767;
            if (prod < -32768)
                prod = -32768;
            r.sample  = prod[15:0];
            r.last    = last;
            r.level   = '0;
            r.voice   = 1'b0;
            r.changed = 1'b0;
            // samples past the frame cap pass through but add no energy
            if (n_samples < FRAME_CAP) begin
                energy += longint'(prod * prod);
                n_samples++;
            end
            if (last) begin
                mean = energy / ((n_samples != 0) ? n_samples : 1);
                root = floor_root(mean);
                if (root > LEVEL_MAX)
                    root = LEVEL_MAX;
                r.level   = root[14:0];
                energy    = 0;
                n_samples = 0;
                if (vad_en_q) begin
                    elapsed = now - quiet_since;
                    if (r.level > thr_q) begin
                        quiet_since = now;
                        active      = 1'b1;
                    end
                    else if (active && elapsed > timeout_q) begin
                        active = 1'b0;
                    end
                    r.voice     = active;
                    r.changed   = (active != shown_voice);
                    shown_voice = active;
                end
                else begin
                    // detection off: flag forced high, voice state untouched
                    r.voice   = 1'b1;
                    r.changed = 1'b0;
                end
            end
            pending_q.push_back(r);
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_result(logic signed [15:0] s, logic fe, logic [14:0] lvl,
                                   logic vd, logic vc);
            voice_result_t w;
            if (pending_q.size() == 0) begin
                flag($sformatf("unexpected result sample=%0d end=%0b level=%0d", s, fe, lvl));
                return;
            end
            w = pending_q.pop_front();
            if (s !== w.sample || fe !== w.last || lvl !== w.level ||
                vd !== w.voice || vc !== w.changed)
                flag($sformatf({"result differs: exp sample=%0d end=%0b level=%0d voice=%0b ",
                                "chg=%0b got sample=%0d end=%0b level=%0d voice=%0b chg=%0b"},
                               w.sample, w.last, w.level, w.voice, w.changed,
                               s, fe, lvl, vd, vc));
        endfunction
    endclass

    voice_scoreboard sb = new();

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Output monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(sample_out, frame_end, rms_level, voice_flag, voice_changed);
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // One input transfer, with optional idle cycles ahead of it
    task automatic push_sample(logic signed [15:0] s, logic last, logic [31:0] now);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        sample_in  = s;
        frame_last = last;
        now_ms     = now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(s, last, now);
    endtask

    // Stop offering input and wait for every predicted result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // APB write followed by a read-back check
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== sb.reg_value(idx))
            sb.flag($sformatf("register %0d reads %0h, expected %0h",
                              idx, prdata, sb.reg_value(idx)));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(logic [31:0] g, logic [31:0] en, logic [31:0] thr,
                             logic [31:0] tmo);
        drain();
        write_reg(REG_GAIN, g);
        write_reg(REG_VAD_EN, en);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    // One frame of random content; kind picks the amplitude class
    task automatic send_frame(int len, int kind);
        int                 i;
        int                 v;
        logic signed [15:0] s;
        // frame-end timestamp: mostly small steps, sometimes a big (wrapping) jump
        if ($urandom_range(0, 19) == 0)
            clock_ms += $urandom;
        else
            clock_ms += $urandom_range(0, 25);
        for (i = 0; i < len; i++) begin
            case (kind)
                0:       v = int'($urandom_range(0, 65535)) - 32768;
                1:       v = int'($urandom_range(0, 256)) - 128;
                2:       v = int'($urandom_range(0, 8192)) - 4096;
                default: v = $urandom_range(0, 1) ? 32767 : -32768;
            endcase
            s = v[15:0];
            push_sample(s, i == len - 1, (i == len - 1) ? clock_ms : $urandom);
        end
    endtask

    // Random frames until the phase quota is reached
    task automatic run_frames(int quota, bit with_hold);
        int  sent;
        int  len;
        bit  held;
        sent = 0;
        held = 1'b0;
        while (sent < quota) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
            send_frame(len, $urandom_range(0, 3));
            sent += len;
            if (with_hold && !held && sent >= 20) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
        end
    endtask

    // Main sequence
    initial begin
        int          mode;
        int          k;
        int          p;
        logic [31:0] thr;
        logic [31:0] tmo;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample_in    = '0;
        frame_last   = 1'b0;
        now_ms       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_req     = 1'b0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        clock_ms     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, rails, level saturation, rounding toward zero
        push_sample(16'sd32767, 1'b1, 32'd0);
        push_sample(-16'sd32768, 1'b1, 32'd0);
        push_sample(16'sd0, 1'b1, 32'd0);
        push_sample(-16'sd1, 1'b1, 32'd0);
        push_sample(16'sd1, 1'b0, $urandom);
        push_sample(-16'sd1, 1'b0, $urandom);
        push_sample(16'sd100, 1'b1, 32'd0);

        // gain write above the limit clamps; scaled values clip at both rails
        configure(32'd127, 32'd0, 32'd0, 32'd0);
        push_sample(16'sd32767, 1'b1, 32'd0);
        push_sample(-16'sd32768, 1'b1, 32'd0);
        push_sample(16'sd20000, 1'b1, 32'd0);

        // small gain: products truncate toward zero
        configure(32'd1, 32'd0, 32'd0, 32'd0);
        push_sample(-16'sd63, 1'b0, $urandom);
        push_sample(-16'sd64, 1'b0, $urandom);
        push_sample(16'sd127, 1'b1, 32'd0);

        // zero gain
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        push_sample(-16'sd32768, 1'b1, 32'hFFFF_FFFF);

        // voice on, hangover across a time wrap, threshold equality
        configure(32'd64, 32'd1, 32'd1000, 32'd10);
        push_sample(16'sd20000, 1'b1, 32'hFFFF_FFF8);
        push_sample(16'sd5, 1'b1, 32'h0000_0001);
        push_sample(16'sd5, 1'b1, 32'h0000_0003);
        push_sample(16'sd1000, 1'b1, 32'h0000_0100);
        push_sample(16'sd1001, 1'b1, 32'h0000_0200);

        // detection off keeps voice state; then top threshold, zero timeout
        configure(32'd64, 32'd0, 32'd1000, 32'd10);
        push_sample(16'sd3, 1'b1, 32'h0000_0300);
        configure(32'd64, 32'd1, 32'd32767, 32'd0);
        push_sample(16'sd32767, 1'b1, 32'h0000_0200);
        push_sample(16'sd32767, 1'b1, 32'h0000_0201);

        // Random phases: receiver idles / sender idles / neither
        for (mode = 0; mode < 3; mode++) begin
            for (k = 0; k < 3; k++) begin
                p = mode * 3 + k;
                case (p)
                    0: configure(32'd64, 32'd1, 32'd200, 32'd20);
                    1: configure(32'd100, 32'd1, 32'd32767, 32'd0);
                    2: configure(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
                    default:
                    begin
                        thr = $urandom_range(0, 1) ? $urandom_range(0, 600)
                                                   : $urandom_range(0, 32767);
                        tmo = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF
                                                          : $urandom_range(0, 60);
                        configure($urandom_range(0, 127), 32'($urandom_range(0, 3) != 0),
                                  thr, tmo);
                    end
                endcase
                send_gap_pct = (mode == 0) ? 8 : (mode == 1) ? 75 : 0;
                recv_gap_pct = (mode == 0) ? 75 : (mode == 1) ? 8 : 0;
                run_frames(PHASE_ITEMS, p == 0);
                // one frame longer than the accumulation cap
                if (p == 8)
                    send_frame(FRAME_CAP + 16, 0);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
